>>> rtl/imq_pkg.sv
// ----------------------------------------------------------------------------
// imq_pkg
// Shared types, codes and constants for the indexed min priority queue.
// ----------------------------------------------------------------------------
package imq_pkg;

    localparam int VERT_W       = 8;
    localparam int NVERT        = 256;
    localparam int KEY_W        = 32;
    localparam int STAT_W       = 3;
    localparam int OCC_W        = 9;
    localparam int MODE_W       = 2;
    localparam int CAPACITY_DEF = 256;

    localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DECREASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXTRACT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd3;
    localparam logic [STAT_W-1:0] ST_ABSENT    = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_LOWER = 3'd5;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
    localparam logic [OP_W-1:0] OP_REJECT  = 5'd2;
    localparam logic [OP_W-1:0] OP_INS     = 5'd3;
    localparam logic [OP_W-1:0] OP_DEC     = 5'd4;
    localparam logic [OP_W-1:0] OP_EX_ROOT = 5'd5;
    localparam logic [OP_W-1:0] OP_UP_RD   = 5'd6;
    localparam logic [OP_W-1:0] OP_UP_KEY  = 5'd7;
    localparam logic [OP_W-1:0] OP_UP_MOVE = 5'd8;
    localparam logic [OP_W-1:0] OP_PLACE   = 5'd9;
    localparam logic [OP_W-1:0] OP_EX_KEY  = 5'd10;
    localparam logic [OP_W-1:0] OP_EX_TAKE = 5'd11;
    localparam logic [OP_W-1:0] OP_EX_LKEY = 5'd12;
    localparam logic [OP_W-1:0] OP_DN_RDL  = 5'd13;
    localparam logic [OP_W-1:0] OP_DN_KL   = 5'd14;
    localparam logic [OP_W-1:0] OP_DN_KR   = 5'd15;
    localparam logic [OP_W-1:0] OP_DN_MOVE = 5'd16;
    localparam logic [OP_W-1:0] OP_FIN_RD  = 5'd17;
    localparam logic [OP_W-1:0] OP_EMIT    = 5'd18;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [VERT_W-1:0]       vertex;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [VERT_W-1:0]       min_vertex;
        logic signed [KEY_W-1:0] min_key;
        logic                    present;
        logic [OCC_W-1:0]        occupancy;
    } t_rsp;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [STAT_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              hit;
        logic              full;
        logic              empty;
        logic              key_lower;
        logic              at_root;
        logic              up_less;
        logic              cnt_one;
        logic              leaf;
        logic              dn_stop;
        logic              out_busy;
    } t_sts;

endpackage

>>> rtl/imq_ctrl.sv
// ----------------------------------------------------------------------------
// imq_ctrl
// Heap op sequencer: one datapath command per cycle unless the result stalls.
// ----------------------------------------------------------------------------
module imq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  imq_pkg::t_sts i_sts,
    output imq_pkg::t_cmd o_cmd
);
    import imq_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_UP   = 4'd2;
    localparam logic [3:0] S_UP1  = 4'd3;
    localparam logic [3:0] S_UP2  = 4'd4;
    localparam logic [3:0] S_EX1  = 4'd5;
    localparam logic [3:0] S_EX2  = 4'd6;
    localparam logic [3:0] S_EX3  = 4'd7;
    localparam logic [3:0] S_DN   = 4'd8;
    localparam logic [3:0] S_DN1  = 4'd9;
    localparam logic [3:0] S_DN2  = 4'd10;
    localparam logic [3:0] S_DN3  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;
    localparam logic [3:0] S_FIN1 = 4'd13;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_NONE;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                n_state  = S_FIN;
                o_cmd.op = OP_REJECT;
                unique case (i_sts.mode)
                    MODE_INSERT: begin
                        if (i_sts.hit) begin
                            o_cmd.status = ST_PRESENT;
                        end else if (i_sts.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.op = OP_INS;
                            n_state  = S_UP;
                        end
                    end
                    MODE_DECREASE: begin
                        if (!i_sts.hit) begin
                            o_cmd.status = ST_ABSENT;
                        end else if (!i_sts.key_lower) begin
                            o_cmd.status = ST_NOT_LOWER;
                        end else begin
                            o_cmd.op = OP_DEC;
                            n_state  = S_UP;
                        end
                    end
                    MODE_EXTRACT: begin
                        if (i_sts.empty) begin
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.op = OP_EX_ROOT;
                            n_state  = S_EX1;
                        end
                    end
                    default: begin
                        o_cmd.status = ST_OK;
                    end
                endcase
            end
            S_UP: begin
                if (i_sts.at_root) begin
                    o_cmd.op = OP_PLACE;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_UP_RD;
                    n_state  = S_UP1;
                end
            end
            S_UP1: begin
                o_cmd.op = OP_UP_KEY;
                n_state  = S_UP2;
            end
            S_UP2: begin
                if (i_sts.up_less) begin
                    o_cmd.op = OP_UP_MOVE;
                    n_state  = S_UP;
                end else begin
                    o_cmd.op = OP_PLACE;
                    n_state  = S_FIN;
                end
            end
            S_EX1: begin
                o_cmd.op = OP_EX_KEY;
                n_state  = S_EX2;
            end
            S_EX2: begin
                o_cmd.op = OP_EX_TAKE;
                n_state  = i_sts.cnt_one ? S_FIN : S_EX3;
            end
            S_EX3: begin
                o_cmd.op = OP_EX_LKEY;
                n_state  = S_DN;
            end
            S_DN: begin
                if (i_sts.leaf) begin
                    o_cmd.op = OP_PLACE;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_DN_RDL;
                    n_state  = S_DN1;
                end
            end
            S_DN1: begin
                o_cmd.op = OP_DN_KL;
                n_state  = S_DN2;
            end
            S_DN2: begin
                o_cmd.op = OP_DN_KR;
                n_state  = S_DN3;
            end
            S_DN3: begin
                if (i_sts.dn_stop) begin
                    o_cmd.op = OP_PLACE;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_DN_MOVE;
                    n_state  = S_DN;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FIN_RD;
                n_state  = S_FIN1;
            end
            S_FIN1: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/imq_dpath.sv
// ----------------------------------------------------------------------------
// imq_dpath
// Heap, key and slot memories, sift registers and the result register.
// ----------------------------------------------------------------------------
module imq_dpath #(
    parameter int CAPACITY = imq_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  imq_pkg::t_req i_in,
    input  imq_pkg::t_cmd i_cmd,
    output imq_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output imq_pkg::t_rsp o_out
);
    import imq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = IW + 2;

    // memories
    logic [VERT_W-1:0]       heap_mem [CAPACITY];
    logic signed [KEY_W-1:0] key_mem  [NVERT];
    logic [IW-1:0]           slot_mem [NVERT];
    logic [NVERT-1:0]        r_vld;

    logic [VERT_W-1:0]       heap_rd;
    logic signed [KEY_W-1:0] key_rd;
    logic [IW-1:0]           slot_rd;

    logic [IW-1:0]           heap_raddr, heap_waddr;
    logic [VERT_W-1:0]       heap_wdata;
    logic                    heap_we;
    logic [VERT_W-1:0]       key_raddr, key_waddr;
    logic signed [KEY_W-1:0] key_wdata;
    logic                    key_we;
    logic [VERT_W-1:0]       slot_raddr, slot_waddr;
    logic [IW-1:0]           slot_wdata;
    logic                    slot_we;

    // working registers
    t_req                    r_req;
    logic [CW-1:0]           r_cnt;
    logic [IW-1:0]           r_i, r_p;
    logic [VERT_W-1:0]       r_vi, r_vp, r_vl, r_vr;
    logic signed [KEY_W-1:0] r_ki, r_kl;
    logic [STAT_W-1:0]       r_status;
    logic [VERT_W-1:0]       r_minv;
    logic signed [KEY_W-1:0] r_mink;
    logic                    r_out_valid;
    t_rsp                    r_out;

    logic [LW-1:0]           idx_l, idx_r;
    logic [IW-1:0]           parent;
    logic                    right_ok, take_l, take_r;
    logic signed [KEY_W-1:0] k_best;
    logic [VERT_W-1:0]       v_best;
    logic [IW-1:0]           i_best;

    assign idx_l  = LW'({r_i, 1'b1});
    assign idx_r  = LW'({r_i, 1'b0}) + LW'(2);
    assign parent = (r_i - IW'(1)) >> 1;

    // child selection for sift-down: strict less, left wins a tie
    assign right_ok = idx_r < LW'(r_cnt);
    assign take_l   = r_kl < r_ki;
    assign k_best   = take_l ? r_kl : r_ki;
    assign take_r   = right_ok && (key_rd < k_best);
    assign v_best   = take_r ? r_vr : r_vl;
    assign i_best   = take_r ? idx_r[IW-1:0] : idx_l[IW-1:0];

    always_comb begin
        o_sts.mode      = r_req.mode;
        o_sts.hit       = r_vld[r_req.vertex] && (CW'(slot_rd) < r_cnt);
        o_sts.full      = (r_cnt == CW'(CAPACITY));
        o_sts.empty     = (r_cnt == '0);
        o_sts.key_lower = r_req.key < key_rd;
        o_sts.at_root   = (r_i == '0);
        o_sts.up_less   = r_ki < key_rd;
        o_sts.cnt_one   = (r_cnt == CW'(1));
        o_sts.leaf      = idx_l >= LW'(r_cnt);
        o_sts.dn_stop   = !take_l && !take_r;
        o_sts.out_busy  = r_out_valid && i_out_stall;
    end

    // memory address and write muxing
    always_comb begin
        heap_raddr = '0;
        heap_we    = 1'b0;
        heap_waddr = r_i;
        heap_wdata = r_vi;
        key_raddr  = heap_rd;
        key_we     = 1'b0;
        key_waddr  = r_req.vertex;
        key_wdata  = r_req.key;
        slot_raddr = r_req.vertex;
        slot_we    = 1'b0;
        slot_waddr = r_vi;
        slot_wdata = r_i;
        case (i_cmd.op) inside
            OP_LOAD: begin
                key_raddr  = i_in.vertex;
                slot_raddr = i_in.vertex;
            end
            OP_INS, OP_DEC: begin
                key_we = 1'b1;
            end
            OP_UP_RD: begin
                heap_raddr = parent;
            end
            OP_UP_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = r_vp;
                slot_we    = 1'b1;
                slot_waddr = r_vp;
            end
            OP_PLACE: begin
                heap_we = 1'b1;
                slot_we = 1'b1;
            end
            OP_EX_KEY: begin
                heap_raddr = IW'(r_cnt - CW'(1));
            end
            OP_DN_RDL: begin
                heap_raddr = idx_l[IW-1:0];
            end
            OP_DN_KL: begin
                heap_raddr = idx_r[IW-1:0];
            end
            OP_DN_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = v_best;
                slot_we    = 1'b1;
                slot_waddr = v_best;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rd <= heap_mem[heap_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rd <= key_mem[key_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd <= slot_mem[slot_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_INS: begin
                    r_cnt <= r_cnt + CW'(1);
                end
                OP_PLACE: begin
                    r_vld[r_vi] <= 1'b1;
                end
                OP_EX_TAKE: begin
                    r_vld[r_vp] <= 1'b0;
                    r_cnt       <= r_cnt - CW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_req <= i_in;
            end
            OP_REJECT: begin
                r_status <= i_cmd.status;
                r_minv   <= '0;
                r_mink   <= '0;
            end
            OP_INS: begin
                r_status <= ST_OK;
                r_minv   <= '0;
                r_mink   <= '0;
                r_i      <= IW'(r_cnt);
                r_vi     <= r_req.vertex;
                r_ki     <= r_req.key;
            end
            OP_DEC: begin
                r_status <= ST_OK;
                r_minv   <= '0;
                r_mink   <= '0;
                r_i      <= slot_rd;
                r_vi     <= r_req.vertex;
                r_ki     <= r_req.key;
            end
            OP_EX_ROOT: begin
                r_status <= ST_OK;
            end
            OP_UP_RD: begin
                r_p <= parent;
            end
            OP_UP_KEY: begin
                r_vp <= heap_rd;
            end
            OP_UP_MOVE: begin
                r_i <= r_p;
            end
            OP_EX_KEY: begin
                r_vp <= heap_rd;
            end
            OP_EX_TAKE: begin
                r_minv <= r_vp;
                r_mink <= key_rd;
                r_vi   <= heap_rd;
                r_i    <= '0;
            end
            OP_EX_LKEY: begin
                r_ki <= key_rd;
            end
            OP_DN_KL: begin
                r_vl <= heap_rd;
            end
            OP_DN_KR: begin
                r_kl <= key_rd;
                r_vr <= heap_rd;
            end
            OP_DN_MOVE: begin
                r_i <= i_best;
            end
            OP_EMIT: begin
                r_out.status     <= r_status;
                r_out.min_vertex <= r_minv;
                r_out.min_key    <= r_mink;
                r_out.present    <= r_vld[r_req.vertex] && (CW'(slot_rd) < r_cnt);
                r_out.occupancy  <= OCC_W'(r_cnt);
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/indexed_min_priority_queue_core.sv
// Queries and rejected requests go straight to the result; insert and decrease-key
// sift the entry up level by level, and extract-min, unless it empties the heap,
// sifts the last entry down from the root. One request at a time: the next is
// accepted the cycle after the result registers; a held result stalls the sequencer.
// Reset (synchronous, active low) empties the heap and marks all vertices absent.
// ----------------------------------------------------------------------------
// indexed_min_priority_queue_core
// Indexed binary min-heap with insert, decrease-key, extract-min and query.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue_core #(
    parameter int CAPACITY = imq_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  imq_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output imq_pkg::t_rsp o_out
);
    import imq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    imq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    imq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

>>> dv/indexed_min_priority_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_priority_queue_checker
// Watches both channels, keeps a shadow indexed min-heap and checks each
// response against the oldest predicted one.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  imq_pkg::t_req i_in,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  imq_pkg::t_rsp i_out,
    output int            o_errors,
    output int            o_pending
);
    import imq_pkg::*;

    logic [VERT_W-1:0]       heap_vtx [NVERT];
    logic signed [KEY_W-1:0] vtx_key  [NVERT];
    int                      vtx_slot [NVERT];
    int                      heap_cnt;
    t_rsp                    rsp_fifo [$];

    function automatic bit holds(logic [VERT_W-1:0] v);
        return vtx_slot[v] < heap_cnt;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [VERT_W-1:0] va, vb;
        va = heap_vtx[a];
        vb = heap_vtx[b];
        heap_vtx[a] = vb;
        heap_vtx[b] = va;
        vtx_slot[vb] = a;
        vtx_slot[va] = b;
    endfunction

    function automatic void bubble_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!(vtx_key[heap_vtx[i]] < vtx_key[heap_vtx[p]])) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void bubble_down(int i);
        int best, l, r;
        forever begin
            best = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < heap_cnt && vtx_key[heap_vtx[l]] < vtx_key[heap_vtx[best]]) best = l;
            if (r < heap_cnt && vtx_key[heap_vtx[r]] < vtx_key[heap_vtx[best]]) best = r;
            if (best == i) break;
            swap_slots(i, best);
            i = best;
        end
    endfunction

    function automatic t_rsp apply_request(t_req rq);
        t_rsp              rs;
        logic [VERT_W-1:0] root, last;
        rs = '0;
        rs.status = ST_OK;
        case (rq.mode)
            MODE_INSERT: begin
                if (holds(rq.vertex)) rs.status = ST_PRESENT;
                else if (heap_cnt >= NVERT) rs.status = ST_FULL;
                else begin
                    vtx_key[rq.vertex] = rq.key;
                    heap_vtx[heap_cnt] = rq.vertex;
                    vtx_slot[rq.vertex] = heap_cnt;
                    heap_cnt++;
                    bubble_up(heap_cnt - 1);
                end
            end
            MODE_DECREASE: begin
                if (!holds(rq.vertex)) rs.status = ST_ABSENT;
                else if (!(rq.key < vtx_key[rq.vertex])) rs.status = ST_NOT_LOWER;
                else begin
                    vtx_key[rq.vertex] = rq.key;
                    bubble_up(vtx_slot[rq.vertex]);
                end
            end
            MODE_EXTRACT: begin
                if (heap_cnt == 0) rs.status = ST_EMPTY;
                else begin
                    root = heap_vtx[0];
                    last = heap_vtx[heap_cnt - 1];
                    rs.min_vertex = root;
                    rs.min_key = vtx_key[root];
                    heap_cnt--;
                    vtx_slot[root] = NVERT;
                    if (heap_cnt > 0) begin
                        heap_vtx[0] = last;
                        vtx_slot[last] = 0;
                        bubble_down(0);
                    end
                end
            end
            default: ;
        endcase
        rs.present = holds(rq.vertex);
        rs.occupancy = OCC_W'(heap_cnt);
        return rs;
    endfunction

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        int   n_err;
        n_err = 0;
        if (!i_rst_n) begin
            heap_cnt = 0;
            o_errors <= 0;
            o_pending <= 0;
            rsp_fifo.delete();
            for (int v = 0; v < NVERT; v++) vtx_slot[v] = NVERT;
        end else begin
            if (i_in_valid && !i_in_stall) rsp_fifo.push_back(apply_request(i_in));
            if (i_out_valid && !i_out_stall) begin
                if (rsp_fifo.size() == 0) begin
                    $error("response with none expected");
                    n_err++;
                end else begin
                    exp_rsp = rsp_fifo.pop_front();
                    if (i_out.status !== exp_rsp.status) begin
                        $error("status exp %0d got %0d", exp_rsp.status, i_out.status);
                        n_err++;
                    end
                    if (i_out.min_vertex !== exp_rsp.min_vertex) begin
                        $error("min_vertex exp %0d got %0d", exp_rsp.min_vertex,
                               i_out.min_vertex);
                        n_err++;
                    end
                    if (i_out.min_key !== exp_rsp.min_key) begin
                        $error("min_key exp %0d got %0d", exp_rsp.min_key, i_out.min_key);
                        n_err++;
                    end
                    if (i_out.present !== exp_rsp.present) begin
                        $error("present exp %0d got %0d", exp_rsp.present, i_out.present);
                        n_err++;
                    end
                    if (i_out.occupancy !== exp_rsp.occupancy) begin
                        $error("occupancy exp %0d got %0d", exp_rsp.occupancy,
                               i_out.occupancy);
                        n_err++;
                    end
                end
            end
            o_errors <= o_errors + n_err;
            o_pending <= rsp_fifo.size();
        end
    end

endmodule

>>> dv/indexed_min_priority_queue_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_min_priority_queue_core_tb
// Directed corner requests, a fill to capacity and random heap traffic, with random
// input gaps and random output stalls; checking is done by the checker.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue_core_tb;
    import imq_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_req in_req = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_rsp out_rsp;
    int   errors;
    int   pending;
    bit   hold_off = 1'b0;
    int   stall_left = 0;

    indexed_min_priority_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_rsp)
    );

    indexed_min_priority_queue_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_req),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_rsp),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 15) - 8;
            default: return $urandom();
        endcase
    endfunction

    task automatic send(logic [MODE_W-1:0] m, logic [VERT_W-1:0] v,
                        logic signed [KEY_W-1:0] k);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_req <= '{mode: m, vertex: v, key: k};
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // receiver stalls; a long hold-off lets the block back up
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (hold_off) out_stall <= 1'b1;
        else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (r < 2) begin
            stall_left = $urandom_range(10, 60);
            out_stall <= 1'b1;
        end else if (r < 70) out_stall <= 1'b0;
        else out_stall <= 1'b1;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [VERT_W-1:0] v;
        int                m;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners: empty extract, absent decrease, queries, ties, extremes
        send(MODE_EXTRACT, 8'd0, '0);
        send(MODE_DECREASE, 8'd5, 32'sd1);
        send(MODE_QUERY, 8'd255, '0);
        send(MODE_INSERT, 8'd0, 32'sh7fffffff);
        send(MODE_INSERT, 8'd255, 32'sh80000000);
        send(MODE_INSERT, 8'd0, 32'sd3);
        send(MODE_INSERT, 8'd10, 32'sd7);
        send(MODE_INSERT, 8'd11, 32'sd7);
        send(MODE_INSERT, 8'd12, 32'sd7);
        send(MODE_DECREASE, 8'd10, 32'sd7);
        send(MODE_DECREASE, 8'd10, 32'sd9);
        send(MODE_DECREASE, 8'd0, 32'sh80000001);
        send(MODE_QUERY, 8'd0, 32'shffffffff);
        for (int i = 0; i < 7; i++) send(MODE_EXTRACT, 8'hff, '0);
        send(MODE_INSERT, 8'd255, 32'sd1);
        send(MODE_EXTRACT, 8'd255, '0);

        // fill to capacity under a long receiver hold-off, then insert a vertex already held
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        for (int i = 0; i < NVERT; i++) send(MODE_INSERT, VERT_W'(i), rand_key());
        send(MODE_INSERT, 8'd77, 32'sd0);
        send(MODE_QUERY, 8'd77, '0);
        for (int i = 0; i < 12; i++) begin
            send(MODE_DECREASE, VERT_W'($urandom_range(0, 255)), rand_key());
        end
        for (int i = 0; i < 128; i++) begin
            send(MODE_EXTRACT, VERT_W'($urandom_range(0, 255)), '0);
        end

        // random traffic, mostly well-formed, over a small vertex pool
        for (int i = 0; i < 130; i++) begin
            v = ($urandom_range(0, 3) == 0) ? VERT_W'($urandom_range(0, 255))
                                            : VERT_W'($urandom_range(0, 31));
            m = $urandom_range(0, 9);
            if (m < 4) send(MODE_INSERT, v, rand_key());
            else if (m < 6) send(MODE_DECREASE, v, rand_key() - $urandom_range(0, 3));
            else if (m < 9) send(MODE_EXTRACT, v, $urandom());
            else send(MODE_QUERY, v, $urandom());
        end
        in_valid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
